### rtl/clmm_pkg.sv
package clmm_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int POS_W       = 12;
    localparam int DIM_W       = 13;
    localparam int NCH_W       = 3;
    localparam int CH_W        = 2;
    localparam int NUM_SAMPLES = 4;
    localparam int CFG_IDX_W   = 2;

    // Largest value a frame size register can hold.
    localparam int DIM_REG_MAX = (1 << DIM_W) - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST   = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
    localparam logic [NCH_W-1:0] CHANNEL_COUNT_RST = 3'd3;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // One classified pixel on its way from the front to the trackers.
    typedef struct packed {
        t_sample [NUM_SAMPLES-1:0] samples;
        logic                      first;
        logic                      frame_end;
        logic [POS_W-1:0]          col;
        logic [POS_W-1:0]          row;
        logic [NCH_W-1:0]          nch;
    } t_item;

    // Extremes of one channel with their positions.
    typedef struct packed {
        t_sample          min_value;
        logic [POS_W-1:0] min_col;
        logic [POS_W-1:0] min_row;
        t_sample          max_value;
        logic [POS_W-1:0] max_col;
        logic [POS_W-1:0] max_row;
    } t_ext;

    // Hand-off of a finished frame from the trackers to the result sequencer.
    typedef struct packed {
        logic             load;
        logic [NCH_W-1:0] nch;
    } t_snap_ctl;

endpackage

### rtl/clmm_front.sv
module clmm_front #(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_DIM      = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [clmm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [clmm_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  clmm_pkg::t_sample                    i_sample_ch0,
    input  clmm_pkg::t_sample                    i_sample_ch1,
    input  clmm_pkg::t_sample                    i_sample_ch2,
    input  clmm_pkg::t_sample                    i_sample_ch3,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output clmm_pkg::t_item                      o_item
);

    localparam int DIM_LIMIT = (MAX_DIM < clmm_pkg::DIM_REG_MAX) ? MAX_DIM
                                                                 : clmm_pkg::DIM_REG_MAX;
    localparam logic [clmm_pkg::DIM_W-1:0] DIM_CAP = DIM_LIMIT[clmm_pkg::DIM_W-1:0];
    localparam logic [clmm_pkg::NCH_W-1:0] NCH_CAP = MAX_CHANNELS[clmm_pkg::NCH_W-1:0];

    logic [clmm_pkg::DIM_W-1:0] r_frame_width;
    logic [clmm_pkg::DIM_W-1:0] r_frame_height;
    logic [clmm_pkg::NCH_W-1:0] r_channel_count;
    logic [clmm_pkg::DIM_W-1:0] r_col;
    logic [clmm_pkg::DIM_W-1:0] r_row;
    logic [clmm_pkg::DIM_W-1:0] n_col;
    logic [clmm_pkg::DIM_W-1:0] n_row;

    logic [clmm_pkg::DIM_W-1:0] w_width;
    logic [clmm_pkg::DIM_W-1:0] w_height;
    logic [clmm_pkg::NCH_W-1:0] w_nch;
    logic                       w_row_end;
    logic                       w_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= clmm_pkg::FRAME_WIDTH_RST;
            r_frame_height  <= clmm_pkg::FRAME_HEIGHT_RST;
            r_channel_count <= clmm_pkg::CHANNEL_COUNT_RST;
        end else if (i_cfg_we) begin
            priority case (i_cfg_idx)
                clmm_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                clmm_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                clmm_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[clmm_pkg::NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one, oversize saturates.
    always_comb begin
        priority if (r_frame_width == '0) begin
            w_width = 13'd1;
        end else if (r_frame_width > DIM_CAP) begin
            w_width = DIM_CAP;
        end else begin
            w_width = r_frame_width;
        end
        priority if (r_frame_height == '0) begin
            w_height = 13'd1;
        end else if (r_frame_height > DIM_CAP) begin
            w_height = DIM_CAP;
        end else begin
            w_height = r_frame_height;
        end
        priority if (r_channel_count == '0) begin
            w_nch = 3'd1;
        end else if (r_channel_count > NCH_CAP) begin
            w_nch = NCH_CAP;
        end else begin
            w_nch = r_channel_count;
        end
    end

    assign w_row_end   = (r_col >= w_width - 13'd1);
    assign w_frame_end = w_row_end && (r_row >= w_height - 13'd1);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item.samples   = {i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};
        o_item.first     = (r_col == '0) && (r_row == '0);
        o_item.frame_end = w_frame_end;
        o_item.col       = r_col[clmm_pkg::POS_W-1:0];
        o_item.row       = r_row[clmm_pkg::POS_W-1:0];
        o_item.nch       = w_nch;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            priority if (w_frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (w_row_end) begin
                n_col = '0;
                n_row = r_row + 13'd1;
            end else begin
                n_col = r_col + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### rtl/clmm_queue.sv
module clmm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clmm_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output clmm_pkg::t_item o_item,
    output logic            o_empty
);

    clmm_pkg::t_item                r_mem [clmm_pkg::QUEUE_DEPTH];
    logic [clmm_pkg::QPTR_W-1:0]    r_wr;
    logic [clmm_pkg::QPTR_W-1:0]    r_rd;
    logic [clmm_pkg::QCNT_W-1:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == clmm_pkg::QCNT_W'(clmm_pkg::QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/clmm_track.sv
module clmm_track #(
    parameter int MAX_CHANNELS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_q_empty,
    input  clmm_pkg::t_item                        i_item,
    output logic                                   o_pop,
    input  logic                                   i_snap_free,
    output clmm_pkg::t_snap_ctl                    o_snap_ctl,
    output clmm_pkg::t_ext [MAX_CHANNELS-1:0]      o_snap_data
);

    clmm_pkg::t_ext [MAX_CHANNELS-1:0] r_ext;
    clmm_pkg::t_ext [MAX_CHANNELS-1:0] n_ext;

    // A frame's last pixel waits until the sequencer can take its results.
    assign o_pop = !i_q_empty && (!i_item.frame_end || i_snap_free);

    always_comb begin
        n_ext = r_ext;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            priority if (i_item.first) begin
                n_ext[c].min_value = i_item.samples[c];
                n_ext[c].min_col   = i_item.col;
                n_ext[c].min_row   = i_item.row;
                n_ext[c].max_value = i_item.samples[c];
                n_ext[c].max_col   = i_item.col;
                n_ext[c].max_row   = i_item.row;
            end else if (i_item.samples[c] < r_ext[c].min_value) begin
                n_ext[c].min_value = i_item.samples[c];
                n_ext[c].min_col   = i_item.col;
                n_ext[c].min_row   = i_item.row;
            end else if (i_item.samples[c] > r_ext[c].max_value) begin
                n_ext[c].max_value = i_item.samples[c];
                n_ext[c].max_col   = i_item.col;
                n_ext[c].max_row   = i_item.row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ext <= n_ext;
        end
    end

    assign o_snap_ctl.load = o_pop && i_item.frame_end;
    assign o_snap_ctl.nch  = i_item.nch;
    assign o_snap_data     = n_ext;

endmodule

### rtl/clmm_emit.sv
module clmm_emit #(
    parameter int MAX_CHANNELS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  clmm_pkg::t_snap_ctl                  i_snap_ctl,
    input  clmm_pkg::t_ext [MAX_CHANNELS-1:0]    i_snap_data,
    output logic                                 o_snap_free,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output clmm_pkg::t_ext                       o_result,
    output logic [clmm_pkg::CH_W-1:0]            o_channel_index,
    output logic                                 o_last
);

    clmm_pkg::t_ext [MAX_CHANNELS-1:0] r_snap;
    logic                              r_busy;
    logic [clmm_pkg::CH_W-1:0]         r_idx;
    logic [clmm_pkg::NCH_W-1:0]        r_cnt;
    logic                              w_xfer;

    assign w_xfer          = r_busy && i_ready;
    assign o_last          = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign o_snap_free     = !r_busy || (w_xfer && o_last);
    assign o_valid         = r_busy;
    assign o_result        = r_snap[0];
    assign o_channel_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (i_snap_ctl.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cnt  <= i_snap_ctl.nch;
        end else if (w_xfer) begin
            r_idx <= r_idx + 2'd1;
            if (o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Results leave from entry 0; the rest move down one place per transfer.
    always_ff @(posedge i_clk) begin
        if (i_snap_ctl.load) begin
            r_snap <= i_snap_data;
        end else if (w_xfer) begin
            for (int i = 0; i < MAX_CHANNELS - 1; i++) begin
                r_snap[i] <= r_snap[i+1];
            end
        end
    end

`ifndef SYNTH
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && !o_last) |=> (r_busy && r_idx == $past(r_idx) + 2'd1))
        else $error("channel index did not advance within a frame's results");

    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_idx == '0))
        else $error("result burst did not start at channel 0");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= MAX_CHANNELS[clmm_pkg::NCH_W-1:0]))
        else $error("result count out of range");
`endif

endmodule

### rtl/channel_min_max_locator_top.sv
// Per-channel minimum/maximum locator for a raster-order pixel stream.
// Input channel: one pixel per transfer (i_in_valid/o_in_ready), four 8-bit
// samples, of which the first channel_count are reported. Output channel:
// one result per active channel per frame (o_out_valid/i_out_ready), channel
// 0 first, with o_last_result set on the final one. Column and row counting
// follows the configured frame width and height; the config port writes one
// register per cycle and should only be used while the block is idle.
// Throughput is one pixel per cycle while o_in_ready is high. A frame's last
// pixel passes through the queue into the result snapshot before its first
// result is valid; results leave at one per cycle while i_out_ready is high.
// A four-entry queue separates the pixel front end from the trackers, and a
// result snapshot lets the next frame be tracked while results drain. Only
// when a frame ends before the previous frame's results are all taken does
// the tracker stage wait, after which the queue fills and o_in_ready drops.
// Reset clears the position counters, queue and result sequencer and restores
// the default 640x480, three-channel setup; the trackers need no reset since
// every frame's first pixel loads them.
module channel_min_max_locator_top #(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_DIM      = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [clmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clmm_pkg::DIM_W-1:0]       i_cfg_data,
    // Pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_sample_ch0,
    input  logic [7:0]                       i_sample_ch1,
    input  logic [7:0]                       i_sample_ch2,
    input  logic [7:0]                       i_sample_ch3,
    // Result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_channel_index,
    output logic [7:0]                       o_min_value,
    output logic [11:0]                      o_min_col,
    output logic [11:0]                      o_min_row,
    output logic [7:0]                       o_max_value,
    output logic [11:0]                      o_max_col,
    output logic [11:0]                      o_max_row,
    output logic                             o_last_result
);

    // Front end to queue.
    logic                               w_push;
    logic                               w_q_full;
    clmm_pkg::t_item                    w_front_item;

    // Queue to trackers.
    logic                               w_pop;
    logic                               w_q_empty;
    clmm_pkg::t_item                    w_q_item;

    // Trackers to result sequencer.
    logic                               w_snap_free;
    clmm_pkg::t_snap_ctl                w_snap_ctl;
    clmm_pkg::t_ext [MAX_CHANNELS-1:0]  w_snap_data;
    clmm_pkg::t_ext                     w_result;

    // Holds the configuration, counts column and row, and tags each pixel
    // as first of frame or last of frame.
    clmm_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_DIM      (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_ch0 (i_sample_ch0),
        .i_sample_ch1 (i_sample_ch1),
        .i_sample_ch2 (i_sample_ch2),
        .i_sample_ch3 (i_sample_ch3),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    clmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty)
    );

    // Updates every channel's extremes; on a frame's last pixel it hands the
    // final values to the sequencer.
    clmm_track #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_track (
        .i_clk       (i_clk),
        .i_q_empty   (w_q_empty),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .i_snap_free (w_snap_free),
        .o_snap_ctl  (w_snap_ctl),
        .o_snap_data (w_snap_data)
    );

    clmm_emit #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_ctl      (w_snap_ctl),
        .i_snap_data     (w_snap_data),
        .o_snap_free     (w_snap_free),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_result        (w_result),
        .o_channel_index (o_channel_index),
        .o_last          (o_last_result)
    );

    assign o_min_value = w_result.min_value;
    assign o_min_col   = w_result.min_col;
    assign o_min_row   = w_result.min_row;
    assign o_max_value = w_result.max_value;
    assign o_max_col   = w_result.max_col;
    assign o_max_row   = w_result.max_row;

endmodule
